// ===== hw/rtl/bpa_pkg.sv =====
// bpa_pkg: shared widths, codes and controller/datapath interface structs
// for the bitmap page allocator; no dependencies
package bpa_pkg;

  // default sizing of the page bitmap
  localparam int MAX_PAGES_DEF     = 4096;
  localparam int MAP_WORD_BITS_DEF = 32;

  // field widths
  localparam int CNT_W      = 13;  // page counts and config registers
  localparam int BASE_W     = 14;  // page index of a scanned word, with headroom
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = ADDR_W - PAGE_SHIFT;  // page index taken from an address
  localparam logic [ADDR_W-1:0] ADDR_BASE = 32'h0010_0000;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // config register indexes
  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  // config reset values
  localparam logic [CNT_W-1:0] TOTAL_RST    = 13'd4096;
  localparam logic [CNT_W-1:0] RESERVED_RST = 13'd1;

  // controller to datapath
  typedef struct packed {
    logic clear;  // clearing pass, write one zero word
    logic start;  // latch request, read word 0
    logic scan;   // examine the word in the read register
    logic load;   // move the finished result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // last word of the clearing pass
    logic done;        // the scanned word settles the request
  } stat_t;

endpackage

// ===== hw/rtl/bpa_ctrl.sv =====
// bpa_ctrl: sequencer for the bitmap page allocator (clear pass, accept,
// word scan, result hand-off); uses bpa_pkg
module bpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output bpa_pkg::cmd_t   cmd,
  input  bpa_pkg::stat_t  st
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign cmd.clear = (state == ST_CLR);
  assign cmd.start = s_tvalid && s_tready;
  assign cmd.scan  = (state == ST_SCAN);
  assign cmd.load  = (state == ST_PUSH) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (st.clear_last) state_next = ST_IDLE;
      ST_IDLE: if (cmd.start) state_next = ST_SCAN;
      ST_SCAN: if (st.done) state_next = ST_PUSH;
      ST_PUSH: if (cmd.load) state_next = ST_IDLE;
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || m_tready))
    else $error("result loaded over an untaken word");

  a_done_goes_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && st.done) |=> (state == ST_PUSH && !s_tready))
    else $error("finished scan did not move to hand-off");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !s_tready && !out_valid)
    else $error("input taken or result shown during clearing pass");

endmodule

// ===== hw/rtl/bpa_datapath.sv =====
// bpa_datapath: bitmap memory, first-fit word search, free check, counters,
// config registers and output register; uses bpa_pkg
module bpa_datapath #(
  parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpa_pkg::cmd_t               cmd,
  output bpa_pkg::stat_t              st,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]   cfg_data,
  input  logic                        in_func,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_addr,
  input  logic                        in_zf,
  output logic [1:0]                  out_status,
  output logic [bpa_pkg::ADDR_W-1:0]  out_granted,
  output logic                        out_clr,
  output logic [bpa_pkg::CNT_W-1:0]   out_free,
  output logic [bpa_pkg::CNT_W-1:0]   out_total
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int OFF_W     = BIT_W + 1;
  localparam int CNT_W     = bpa_pkg::CNT_W;
  localparam int BASE_W    = bpa_pkg::BASE_W;
  localparam int ADDR_W    = bpa_pkg::ADDR_W;
  localparam int IDX_W     = bpa_pkg::IDX_W;
  localparam int SHIFT     = bpa_pkg::PAGE_SHIFT;
  localparam logic [31:0]       MAXP     = 32'(MAX_PAGES);
  localparam logic [BASE_W-1:0] MWB_B    = BASE_W'(MAP_WORD_BITS);
  localparam logic [IDX_W-1:0]  MWB_I    = IDX_W'(MAP_WORD_BITS);
  localparam logic [WA_W-1:0]   LAST_W   = WA_W'(MAP_WORDS - 1);

  // bitmap memory, one bit per page, set = allocated
  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rdata;
  logic [WA_W-1:0]          raddr;
  logic [WA_W-1:0]          waddr;
  logic [MAP_WORD_BITS-1:0] wdata;
  logic                     we;

  logic [CNT_W-1:0]  page_total;
  logic [CNT_W-1:0]  reserved_pages;
  logic [CNT_W-1:0]  used_count;
  logic [WA_W-1:0]   clr_ptr;
  logic [WA_W-1:0]   chk_word;
  logic [BASE_W-1:0] chk_base;

  logic              req_func;
  logic [ADDR_W-1:0] req_addr;
  logic              req_zf;

  logic [1:0]        pend_status;
  logic [ADDR_W-1:0] pend_granted;
  logic              pend_clr;

  logic [CNT_W-1:0]  eff_tot;
  logic [CNT_W-1:0]  eff_res;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  freec;

  logic [BASE_W-1:0] tot_b;
  logic [BASE_W-1:0] res_b;
  logic [BASE_W-1:0] lo_d;
  logic [BASE_W-1:0] hi_d;
  logic [OFF_W-1:0]  lo;
  logic [OFF_W-1:0]  hi;
  logic [MAP_WORD_BITS-1:0] cand;
  logic              hit;
  logic [BIT_W-1:0]  hit_off;
  logic              at_end;
  logic [BASE_W-1:0] grant_idx;
  logic [ADDR_W-1:0] grant_addr;

  logic [ADDR_W-1:0] f_off;
  logic [IDX_W-1:0]  f_idx;
  logic [IDX_W-1:0]  f_pos;
  logic              f_bad;
  logic              f_in_word;
  logic              f_bit;

  logic              commit_set;
  logic              commit_clr;

  // effective range
  assign eff_tot = (32'(page_total) > MAXP) ? MAXP[CNT_W-1:0] : page_total;
  assign eff_res = (reserved_pages > eff_tot) ? eff_tot : reserved_pages;
  assign avail   = eff_tot - eff_res;
  assign freec   = (avail > used_count) ? (avail - used_count) : '0;

  // allocatable bit window of the scanned word
  assign tot_b  = BASE_W'(eff_tot);
  assign res_b  = BASE_W'(eff_res);
  assign at_end = (chk_base >= tot_b);

  always_comb begin
    lo_d = (res_b > chk_base) ? (res_b - chk_base) : '0;
    hi_d = (tot_b > chk_base) ? (tot_b - chk_base) : '0;
    lo   = (lo_d >= MWB_B) ? OFF_W'(MAP_WORD_BITS) : lo_d[OFF_W-1:0];
    hi   = (hi_d >= MWB_B) ? OFF_W'(MAP_WORD_BITS) : hi_d[OFF_W-1:0];
  end

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      cand[b] = !rdata[b] && (OFF_W'(b) >= lo) && (OFF_W'(b) < hi);
    end
  end

  // lowest free page of the word
  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_off = BIT_W'(b);
      end
    end
  end

  assign grant_idx  = chk_base + BASE_W'(hit_off);
  assign grant_addr = (ADDR_W'(grant_idx) << SHIFT) + bpa_pkg::ADDR_BASE;

  // free request: address back to page index
  assign f_off     = req_addr - bpa_pkg::ADDR_BASE;
  assign f_idx     = f_off[ADDR_W-1:SHIFT];
  assign f_bad     = (f_off[SHIFT-1:0] != '0) || (f_idx < IDX_W'(eff_res))
                     || (f_idx >= IDX_W'(eff_tot));
  assign f_pos     = f_idx - IDX_W'(chk_base);
  assign f_in_word = (f_pos < MWB_I);
  assign f_bit     = rdata[f_pos[BIT_W-1:0]];

  always_comb begin
    if (req_func == bpa_pkg::FUNC_ALLOC) st.done = hit || at_end;
    else st.done = f_bad || f_in_word;
  end
  assign st.clear_last = (clr_ptr == LAST_W);

  assign commit_set = cmd.scan && (req_func == bpa_pkg::FUNC_ALLOC) && hit;
  assign commit_clr = cmd.scan && (req_func == bpa_pkg::FUNC_FREE) && !f_bad
                      && f_in_word && f_bit;

  // memory ports
  assign raddr = cmd.start ? '0 : (chk_word + 1'b1);
  assign we    = cmd.clear || commit_set || commit_clr;

  always_comb begin
    priority if (cmd.clear) begin
      waddr = clr_ptr;
      wdata = '0;
    end else if (commit_set) begin
      waddr = chk_word;
      wdata = rdata | (MAP_WORD_BITS'(1) << hit_off);
    end else begin
      waddr = chk_word;
      wdata = rdata & ~(MAP_WORD_BITS'(1) << f_pos[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      page_total     <= bpa_pkg::TOTAL_RST;
      reserved_pages <= bpa_pkg::RESERVED_RST;
      used_count     <= '0;
      clr_ptr        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bpa_pkg::REG_TOTAL:    page_total     <= cfg_data;
          bpa_pkg::REG_RESERVED: reserved_pages <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) clr_ptr <= clr_ptr + 1'b1;
      if (commit_set) used_count <= used_count + 1'b1;
      else if (commit_clr && used_count != '0) used_count <= used_count - 1'b1;
    end
  end

  // request, scan position and pending result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func <= in_func;
      req_addr <= in_addr;
      req_zf   <= in_zf;
      chk_word <= '0;
      chk_base <= '0;
    end else if (cmd.scan) begin
      if (!st.done) begin
        chk_word <= chk_word + 1'b1;
        chk_base <= chk_base + MWB_B;
      end else begin
        if (req_func == bpa_pkg::FUNC_ALLOC) begin
          pend_status  <= hit ? bpa_pkg::STATUS_OK : bpa_pkg::STATUS_FULL;
          pend_granted <= hit ? grant_addr : '0;
          pend_clr     <= hit && req_zf;
        end else begin
          pend_status  <= commit_clr ? bpa_pkg::STATUS_OK : bpa_pkg::STATUS_INVALID;
          pend_granted <= '0;
          pend_clr     <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status  <= pend_status;
      out_granted <= pend_granted;
      out_clr     <= pend_clr;
      out_free    <= freec;
      out_total   <= avail;
    end
  end

endmodule

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
// bitmap_page_allocator_core: top level of the first-fit bitmap page allocator
// instantiates bpa_ctrl and bpa_datapath; uses bpa_pkg
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   s_*     | s_tvalid / s_tready | tuser: func; tdata: free address, zero_fill
//   m_*     | m_tvalid / m_tready | tuser: status; tdata: granted_addr,
//           |                     |   clear_request, free_count, total_count
//   cfg_*   | cfg_valid/cfg_ready | cfg_index 0 page total, 1 reserved count
//
// after reset a clearing pass zeroes the bitmap's MAP_WORDS words (128 with the
// defaults), one word a cycle; no request is taken until it ends, config
// writes are always taken
// a request reads n bitmap words between accept and result, one per cycle
// through the single read port, from word 0 up to the word that
// holds the granted or freed page (allocation with no free page reads
// ceil(total/MAP_WORD_BITS) + 1 words, a malformed free reads one)
// the result sits in an output register; a new request is accepted while it
// waits, and its scan completes before the hand-off stalls on m_tready
module bitmap_page_allocator_core #(
  parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request words
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,   // [31:0] free address, [32] zero_fill
  input  logic                       s_tuser,   // [0] func
  // result words
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,   // [31:0] granted_addr, [32] clear_request,
                                                // [45:33] free_count, [58:46] total_count
  output logic [1:0]                 m_tuser,   // [1:0] status
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_data
);

  bpa_pkg::cmd_t   cmd;
  bpa_pkg::stat_t  st;

  logic [bpa_pkg::ADDR_W-1:0] out_granted;
  logic                       out_clr;
  logic [bpa_pkg::CNT_W-1:0]  out_free;
  logic [bpa_pkg::CNT_W-1:0]  out_total;

  // registers can be written at any time
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  bpa_datapath #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_func     (s_tuser),
    .in_addr     (s_tdata[31:0]),
    .in_zf       (s_tdata[32]),
    .out_status  (m_tuser),
    .out_granted (out_granted),
    .out_clr     (out_clr),
    .out_free    (out_free),
    .out_total   (out_total)
  );

  // pack result fields, zero filled to whole bytes
  assign m_tdata = {5'b0, out_total, out_free, out_clr, out_granted};

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking regression for bitmap_page_allocator_core
// first-fit page predictor, stream driver and monitor; uses bpa_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;

  // request word as the driver holds it
  typedef struct packed {
    logic                       func;
    logic [bpa_pkg::ADDR_W-1:0] addr;
    logic                       zf;
  } page_req_t;

  // result word, field by field
  typedef struct packed {
    logic [1:0]                 status;
    logic [bpa_pkg::ADDR_W-1:0] grant;
    logic                       clear;
    logic [bpa_pkg::CNT_W-1:0]  free_cnt;
    logic [bpa_pkg::CNT_W-1:0]  avail_pages;
  } page_result_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [39:0]       s_tdata   = '0;   // [31:0] free address, [32] zero_fill
  logic              s_tuser   = 1'b0; // [0] func
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [63:0]       m_tdata;          // [31:0] granted_addr, [32] clear_request,
                                       // [45:33] free_count, [58:46] total_count
  logic [1:0]        m_tuser;          // [1:0] status
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [bpa_pkg::CNT_W-1:0] cfg_data = '0;

  // predictor state: one bit per page, count of held pages, register copies
  bit [bpa_pkg::MAX_PAGES_DEF-1:0] page_used;
  int                              pages_held;
  logic [bpa_pkg::CNT_W-1:0]       total_reg    = bpa_pkg::TOTAL_RST;
  logic [bpa_pkg::CNT_W-1:0]       reserved_reg = bpa_pkg::RESERVED_RST;

  page_req_t    pending_words[$];     // requests not yet offered
  page_result_t expected_results[$];  // predicted results in order

  // driver and receiver bookkeeping
  page_req_t cur_req   = '0;
  bit        src_offer = 1'b0;
  bit        src_taken = 1'b0;
  int        src_gap   = 0;
  bit        sink_taken = 1'b0;
  bit        sink_rdy   = 1'b0;
  int        sink_gap   = 0;
  int        sink_hold  = 0;
  int        hold_req   = 0;
  bit        steady     = 1'b0;  // no random gaps on either side while set

  int errors      = 0;
  int words_sent  = 0;
  int results_in  = 0;
  int reg_writes  = 0;
  int seen_ok     = 0;
  int seen_full   = 0;
  int seen_bad    = 0;

  bitmap_page_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // run limit, well above the slowest legal run
  initial begin
    #2000000;
    $display("bitmap_page_allocator_core regression: fail");
    $finish;
  end

  // effective page total, clamped to capacity
  function automatic int page_limit();
    return (int'(total_reg) > bpa_pkg::MAX_PAGES_DEF) ? bpa_pkg::MAX_PAGES_DEF
                                                      : int'(total_reg);
  endfunction

  // effective reserved count, clamped to the total
  function automatic int reserved_floor();
    int lim;
    lim = page_limit();
    return (int'(reserved_reg) > lim) ? lim : int'(reserved_reg);
  endfunction

  function automatic logic [bpa_pkg::ADDR_W-1:0] page_address(int idx);
    logic [bpa_pkg::ADDR_W-1:0] a;
    a = idx;
    return bpa_pkg::ADDR_BASE + (a << bpa_pkg::PAGE_SHIFT);
  endfunction

  // first-fit grant or release, applied to the predictor state
  function automatic page_result_t allocate_or_release(page_req_t rq);
    page_result_t               r;
    int                         lim;
    int                         base;
    int                         pick;
    int                         avail;
    logic [bpa_pkg::ADDR_W-1:0] off;
    logic [bpa_pkg::IDX_W-1:0]  idx;
    lim  = page_limit();
    base = reserved_floor();
    r    = '0;
    if (rq.func == bpa_pkg::FUNC_ALLOC) begin
      pick = -1;
      // walk down so the lowest free page wins
      for (int i = lim - 1; i >= base; i--)
        if (!page_used[i]) pick = i;
      if (pick >= 0) begin
        page_used[pick] = 1'b1;
        pages_held++;
        r.grant = page_address(pick);
        r.clear = rq.zf;
      end else begin
        r.status = bpa_pkg::STATUS_FULL;
      end
    end else begin
      off = rq.addr - bpa_pkg::ADDR_BASE;
      idx = off[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
      // misaligned, reserved, out of range or already free
      if (off[bpa_pkg::PAGE_SHIFT-1:0] != '0 || int'(idx) < base || int'(idx) >= lim ||
          !page_used[idx]) begin
        r.status = bpa_pkg::STATUS_INVALID;
      end else begin
        page_used[idx] = 1'b0;
        if (pages_held > 0) pages_held--;
      end
    end
    avail = lim - base;
    r.avail_pages = bpa_pkg::CNT_W'(avail);
    r.free_cnt    = bpa_pkg::CNT_W'((avail > pages_held) ? avail - pages_held : 0);
    return r;
  endfunction

  // random page in [lo, hi) whose bit equals want, -1 if none
  function automatic int find_page(int lo, int hi, bit want);
    int start;
    int i;
    if (hi <= lo) return -1;
    start = $urandom_range(lo, hi - 1);
    for (int k = 0; k < hi - lo; k++) begin
      i = lo + (start - lo + k) % (hi - lo);
      if (page_used[i] == want) return i;
    end
    return -1;
  endfunction

  // mostly allocs and frees of held pages, the rest malformed frees
  function automatic page_req_t next_request();
    page_req_t rq;
    int        lim;
    int        base;
    int        pick;
    int        roll;
    lim     = page_limit();
    base    = reserved_floor();
    rq.func = bpa_pkg::FUNC_FREE;
    rq.addr = $urandom;
    rq.zf   = 1'($urandom_range(0, 1));
    roll    = $urandom_range(0, 99);
    if (roll < 45) begin
      rq.func = bpa_pkg::FUNC_ALLOC;
    end else if (roll < 80) begin
      pick = find_page(base, lim, 1'b1);
      if (pick < 0) rq.func = bpa_pkg::FUNC_ALLOC;
      else rq.addr = page_address(pick);
    end else if (roll < 85) begin
      // fully random address
    end else if (roll < 90) begin
      rq.addr = page_address($urandom_range(0, bpa_pkg::MAX_PAGES_DEF - 1)) |
                $urandom_range(1, 4095);
    end else if (roll < 94) begin
      rq.addr = page_address(base > 0 ? $urandom_range(0, base - 1)
                                      : lim + $urandom_range(0, 40));
    end else if (roll < 97) begin
      rq.addr = page_address(lim + $urandom_range(0, 40));
    end else begin
      pick = find_page(base, lim, 1'b0);
      rq.addr = page_address(pick < 0 ? $urandom_range(0, bpa_pkg::MAX_PAGES_DEF - 1)
                                      : pick);
    end
    return rq;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // request driver: one word at a time from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      src_offer = 1'b0;
    end else begin
      if (src_taken) begin
        src_taken = 1'b0;
        src_offer = 1'b0;
        src_gap   = draw_gap();
      end
      if (!src_offer) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_words.size() > 0) begin
          cur_req   = pending_words.pop_front();
          src_offer = 1'b1;
        end
      end
    end
    s_tvalid <= src_offer;
    s_tuser  <= cur_req.func;
    s_tdata  <= {7'd0, cur_req.zf, cur_req.addr};
  end

  // result receiver: per-word gap plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      sink_hold = hold_req;
      hold_req  = 0;
    end
    if (sink_taken) begin
      sink_taken = 1'b0;
      sink_gap   = draw_gap();
    end
    if (sink_hold > 0) begin
      sink_hold--;
      sink_rdy = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      sink_rdy = 1'b0;
    end else begin
      sink_rdy = 1'b1;
    end
    m_tready <= sink_rdy;
  end

  // monitor: check results, predict accepted requests
  always @(posedge clk) begin
    page_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_in++;
        sink_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result word with nothing expected, expected none actual %h/%h",
                   $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",        want.status,      m_tuser);
          check_field("granted_addr",  want.grant,       m_tdata[31:0]);
          check_field("clear_request", want.clear,       m_tdata[32]);
          check_field("free_count",    want.free_cnt,    m_tdata[45:33]);
          check_field("total_count",   want.avail_pages, m_tdata[58:46]);
          if (want.status == bpa_pkg::STATUS_OK) seen_ok++;
          else if (want.status == bpa_pkg::STATUS_FULL) seen_full++;
          else seen_bad++;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(allocate_or_release(cur_req));
        src_taken = 1'b1;
        words_sent++;
      end
    end
  end

  task automatic push_req(logic func, logic [bpa_pkg::ADDR_W-1:0] addr, logic zf);
    page_req_t rq;
    rq.func = func;
    rq.addr = addr;
    rq.zf   = zf;
    pending_words.push_back(rq);
  endtask

  // wait until every request is in and every result is out
  task automatic settle();
    while (pending_words.size() != 0 || src_offer || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [bpa_pkg::CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bpa_pkg::REG_TOTAL) total_reg = value;
    else reserved_reg = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // keep a short queue so frees pick pages the predictor already holds
  task automatic feed(int count, bit squeeze, bit pause_mid);
    for (int i = 0; i < count; i++) begin
      while (pending_words.size() >= 2) @(negedge clk);
      if (squeeze && i == 10) hold_req = 300;
      if (pause_mid && i == count / 2) settle();
      pending_words.push_back(next_request());
    end
  endtask

  task automatic run_phase(int total, int reserved, int count, bit quiet, bit squeeze,
                           bit pause_mid);
    settle();
    write_reg(bpa_pkg::REG_TOTAL, bpa_pkg::CNT_W'(total));
    write_reg(bpa_pkg::REG_RESERVED, bpa_pkg::CNT_W'(reserved));
    steady = quiet;
    feed(count, squeeze, pause_mid);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset settings: grants, frees and every kind of bad free
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0000_0000, 1'b0);    // page 1
    push_req(bpa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 1'b1);    // page 2, zero fill
    push_req(bpa_pkg::FUNC_FREE,  page_address(1), 1'b0);
    push_req(bpa_pkg::FUNC_FREE,  page_address(1), 1'b1);  // already free
    push_req(bpa_pkg::FUNC_FREE,  bpa_pkg::ADDR_BASE, 1'b0);  // reserved page
    push_req(bpa_pkg::FUNC_FREE,  32'h0000_0000, 1'b0);    // below the base, wraps
    push_req(bpa_pkg::FUNC_FREE,  32'h0010_2001, 1'b0);    // misaligned
    push_req(bpa_pkg::FUNC_FREE,  32'hFFFF_FFFF, 1'b1);
    push_req(bpa_pkg::FUNC_FREE,  page_address(bpa_pkg::MAX_PAGES_DEF), 1'b0);  // past end
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0000_0000, 1'b1);    // page 1 again
    settle();

    // no pages at all
    write_reg(bpa_pkg::REG_TOTAL, 13'd0);
    write_reg(bpa_pkg::REG_RESERVED, 13'd0);
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b1);
    push_req(bpa_pkg::FUNC_FREE,  page_address(1), 1'b0);
    settle();

    // total above capacity, one page left at the very top
    write_reg(bpa_pkg::REG_TOTAL, 13'h1FFF);
    write_reg(bpa_pkg::REG_RESERVED, bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES_DEF - 1));
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b0);
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b1);            // full
    push_req(bpa_pkg::FUNC_FREE,  page_address(bpa_pkg::MAX_PAGES_DEF - 1), 1'b0);
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b1);
    settle();

    // reserved above total: nothing allocatable
    write_reg(bpa_pkg::REG_RESERVED, 13'h1FFF);
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b0);
    push_req(bpa_pkg::FUNC_FREE,  page_address(bpa_pkg::MAX_PAGES_DEF - 1), 1'b0);
    settle();

    // no reservation: page 0 is handed out
    write_reg(bpa_pkg::REG_TOTAL, bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES_DEF));
    write_reg(bpa_pkg::REG_RESERVED, 13'd0);
    push_req(bpa_pkg::FUNC_ALLOC, 32'h0, 1'b0);
    push_req(bpa_pkg::FUNC_FREE,  page_address(2), 1'b0);

    // random phases over a spread of settings, small totals to reach full often
    run_phase(16,    0,    150, 1'b0, 1'b0, 1'b0);
    run_phase(40,    3,    150, 1'b1, 1'b1, 1'b0);  // long receiver hold-off
    run_phase(4096,  1,    100, 1'b0, 1'b0, 1'b1);  // sender drains mid-phase
    run_phase(1,     0,     60, 1'b0, 1'b0, 1'b0);  // stale pages floor free_count
    run_phase(100,   90,   150, 1'b0, 1'b0, 1'b0);
    run_phase(8191,  4090,  90, 1'b0, 1'b0, 1'b0);  // full-length scans
    run_phase(33,    31,    90, 1'b1, 1'b0, 1'b0);
    run_phase(64,    0,    200, 1'b0, 1'b0, 1'b0);
    run_phase(0,     0,     30, 1'b0, 1'b0, 1'b0);
    run_phase(200,   4096,  30, 1'b0, 1'b0, 1'b0);
    run_phase(2000,  1000, 150, 1'b0, 1'b0, 1'b0);

    // drain, then watch for stray results
    steady = 1'b0;
    settle();
    repeat (150) @(negedge clk);

    $display("covered %0d request words and %0d result words over %0d register writes",
             words_sent, results_in, reg_writes);
    $display("outcomes: %0d granted or released, %0d full, %0d rejected frees, %0d errors",
             seen_ok, seen_full, seen_bad, errors);
    if (errors == 0) begin
      $display("bitmap_page_allocator_core regression: pass");
    end else begin
      $display("bitmap_page_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
